// ===== hdl/mst_pkg.sv =====
// message subscription table package: types, codes and constants
// used by every module of the block
`default_nettype none
package mst_pkg;
   localparam int POOL_ENTRIES_DEF = 32;
   localparam int HASH_SLOTS_DEF = 64;
   localparam int MAX_OUT = 32;

   typedef enum logic [1:0] {
      OP_REG = 2'd0,
      OP_UNREG = 2'd1,
      OP_DISP = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0,
      ST_POOL_FULL = 3'd1,
      ST_TABLE_FULL = 3'd2,
      ST_BAD_HANDLE = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_CHECK,
      S_PROBE_RD,
      S_PROBE_KEY,
      S_PROBE_EVAL,
      S_WALK_RD,
      S_WALK_EVAL,
      S_REG_WRITE,
      S_UNREG_WRITE,
      S_DISP_RD,
      S_DISP_OUT,
      S_RESP,
      S_CLEAR
   } state_type;
endpackage
`default_nettype wire

// ===== hdl/mst_slot_ram.sv =====
// slot head memory: one write port, one registered read port
// depends on mst_pkg
`default_nettype none
module mst_slot_ram
   import mst_pkg::*;
#(
   parameter int SLOTS = HASH_SLOTS_DEF,
   parameter int PW = 6
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(SLOTS)-1:0] wr_addr,
   input  wire logic [PW-1:0]            wr_data,
   input  wire logic [$clog2(SLOTS)-1:0] rd_addr,
   output logic      [PW-1:0]            rd_data
);
   logic [PW-1:0] mem [SLOTS];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== hdl/mst_entry_ram.sv =====
// handler entry memory: key, handler, param, next, tag fields per entry
// depends on mst_pkg
`default_nettype none
module mst_entry_ram
   import mst_pkg::*;
#(
   parameter int ENTRIES = POOL_ENTRIES_DEF,
   parameter int W = 166
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(ENTRIES)-1:0] wr_addr,
   input  wire logic [W-1:0]               wr_data,
   input  wire logic [$clog2(ENTRIES)-1:0] rd_addr,
   output logic      [W-1:0]               rd_data
);
   logic [W-1:0] mem [ENTRIES];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== hdl/message_subscription_table.sv =====
// Message subscription table. Keys hash by key modulo HASH_SLOTS into a slot
// memory with linear probing; each slot heads a handler list held in an entry
// memory drawn from a free list. Each memory has one write port and one
// registered read port, so probing reads each slot head and then its head
// entry, and each list entry walked is read in turn (register walks to the
// tail, unregister walks each key slot, dispatch emits one transfer per entry).
// After reset a clearing pass over every slot and pool entry builds empty
// slots and the free chain before the first request transfer is taken.
// depends on mst_pkg, mst_slot_ram, mst_entry_ram
`default_nettype none
module message_subscription_table
   import mst_pkg::*;
#(
   parameter int POOL_ENTRIES = POOL_ENTRIES_DEF,
   parameter int HASH_SLOTS = HASH_SLOTS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // op[1:0], msg_key[65:2], handler_id[81:66], handler_param[145:82],
   // handle_index[151:146], handle_tag[167:152], event_param1[231:168],
   // event_param2[295:232]
   input  wire logic [295:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // status[2:0], out_index[7:3], out_tag[23:8], call_handler[39:24],
   // call_param0[103:40], call_param1[167:104], call_param2[231:168]
   output logic [231:0]      rsp_tdata,
   output logic              rsp_tlast
);
   localparam int EW = $clog2(POOL_ENTRIES);
   localparam int SW = $clog2(HASH_SLOTS);
   localparam int PW = EW + 1;
   localparam int RW = 64 + 16 + 64 + PW + 16;
   localparam int CLR = (HASH_SLOTS > POOL_ENTRIES) ? HASH_SLOTS : POOL_ENTRIES;
   localparam int CW = $clog2(CLR + 1);
   localparam logic [PW-1:0] NIL = {PW{1'b1}};

   state_type state_ff, state_in;
   logic [1:0]   op_ff, op_in;
   logic [63:0]  key_ff, key_in;
   logic [15:0]  hid_ff, hid_in;
   logic [63:0]  hpar_ff, hpar_in;
   logic [5:0]   hidx_ff, hidx_in;
   logic [15:0]  htag_ff, htag_in;
   logic [63:0]  ep1_ff, ep1_in, ep2_ff, ep2_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic [SW:0]  pcnt_ff, pcnt_in;
   logic [PW-1:0] head_ff, head_in;
   logic [PW-1:0] cur_ff, cur_in, prev_ff, prev_in;
   logic [PW-1:0] free_ff, free_in;
   logic [EW:0]  wcnt_ff, wcnt_in;
   logic [POOL_ENTRIES-1:0] used_ff, used_in;
   logic [CW-1:0] clr_ff, clr_in;
   logic [2:0]   st_ff, st_in;
   logic [4:0]   oidx_ff, oidx_in;
   logic [15:0]  otag_ff, otag_in;
   logic [15:0]  och_ff, och_in;
   logic [63:0]  op0_ff, op0_in;
   logic         olast_ff, olast_in;
   logic [RW-1:0] ent_ff, ent_in;

   logic          s_we;
   logic [SW-1:0] s_wa, s_ra;
   logic [PW-1:0] s_wd, s_rd;
   logic          e_we;
   logic [EW-1:0] e_wa, e_ra;
   logic [RW-1:0] e_wd, e_rd;

   logic [63:0]   rd_key, rd_par;
   logic [15:0]   rd_hnd, rd_tag;
   logic [PW-1:0] rd_next;
   assign rd_key  = e_rd[63:0];
   assign rd_hnd  = e_rd[79:64];
   assign rd_par  = e_rd[143:80];
   assign rd_next = e_rd[144 +: PW];
   assign rd_tag  = e_rd[144+PW +: 16];

   mst_slot_ram #(.SLOTS(HASH_SLOTS), .PW(PW)) u_slot (
      .clock(clock), .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd),
      .rd_addr(s_ra), .rd_data(s_rd));
   mst_entry_ram #(.ENTRIES(POOL_ENTRIES), .W(RW)) u_entry (
      .clock(clock), .wr_en(e_we), .wr_addr(e_wa), .wr_data(e_wd),
      .rd_addr(e_ra), .rd_data(e_rd));

   function automatic logic [RW-1:0] pack_ent(logic [63:0] k, logic [15:0] h,
         logic [63:0] p, logic [PW-1:0] nx, logic [15:0] t);
      pack_ent = {t, nx, p, h, k};
   endfunction

   function automatic logic och_valid();
      och_valid = (op_ff == OP_DISP) && (st_ff == ST_OK);
   endfunction

   logic head_hit;
   assign head_hit = !head_ff[EW] && (rd_key == key_ff);

   always_comb begin
      state_in = state_ff;
      op_in = op_ff; key_in = key_ff; hid_in = hid_ff; hpar_in = hpar_ff;
      hidx_in = hidx_ff; htag_in = htag_ff; ep1_in = ep1_ff; ep2_in = ep2_ff;
      slot_in = slot_ff; pcnt_in = pcnt_ff; head_in = head_ff;
      cur_in = cur_ff; prev_in = prev_ff; free_in = free_ff; wcnt_in = wcnt_ff;
      used_in = used_ff; clr_in = clr_ff; st_in = st_ff; oidx_in = oidx_ff;
      otag_in = otag_ff; och_in = och_ff; op0_in = op0_ff; olast_in = olast_ff;
      ent_in = ent_ff;
      s_we = 1'b0; s_wa = slot_ff; s_wd = NIL; s_ra = slot_ff;
      e_we = 1'b0; e_wa = cur_ff[EW-1:0]; e_wd = e_rd; e_ra = cur_ff[EW-1:0];
      case (state_ff)
         S_CLEAR: begin
            if (clr_ff < CW'(HASH_SLOTS)) begin
               s_we = 1'b1; s_wa = clr_ff[SW-1:0]; s_wd = NIL;
            end
            if (clr_ff < CW'(POOL_ENTRIES)) begin
               e_we = 1'b1; e_wa = clr_ff[EW-1:0];
               e_wd = pack_ent(64'd0, 16'd0, 64'd0,
                  (clr_ff == CW'(POOL_ENTRIES - 1)) ? NIL : PW'(clr_ff + 1'b1),
                  16'd0);
            end
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CW'(CLR - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               op_in = req_tdata[1:0]; key_in = req_tdata[65:2];
               hid_in = req_tdata[81:66]; hpar_in = req_tdata[145:82];
               hidx_in = req_tdata[151:146]; htag_in = req_tdata[167:152];
               ep1_in = req_tdata[231:168]; ep2_in = req_tdata[295:232];
               st_in = ST_OK; oidx_in = '0; otag_in = '0; och_in = '0;
               op0_in = '0; olast_in = 1'b1;
               slot_in = SW'(req_tdata[65:2] % HASH_SLOTS);
               pcnt_in = '0;
               cur_in = PW'(req_tdata[151:146]);
               e_ra = req_tdata[146 +: EW];
               case (op_type'(req_tdata[1:0]))
                  OP_REG: begin
                     if (free_ff[EW]) begin
                        st_in = ST_POOL_FULL; state_in = S_RESP;
                     end else state_in = S_PROBE_RD;
                  end
                  OP_UNREG: begin
                     if ({1'b0, req_tdata[151:146]} >= 7'(POOL_ENTRIES)) begin
                        st_in = ST_BAD_HANDLE; state_in = S_RESP;
                     end else state_in = S_CHECK;
                  end
                  OP_DISP: state_in = S_PROBE_RD;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_CHECK: begin
            // entry read issued in idle from the request index
            if (!used_ff[cur_ff[EW-1:0]] || rd_tag != htag_ff) begin
               st_in = ST_BAD_HANDLE; state_in = S_RESP;
            end else begin
               key_in = rd_key;
               slot_in = SW'(rd_key % HASH_SLOTS);
               state_in = S_PROBE_RD;
            end
         end
         S_PROBE_RD: begin
            s_ra = slot_ff;
            state_in = S_PROBE_KEY;
         end
         S_PROBE_KEY: begin
            head_in = s_rd;
            e_ra = s_rd[EW-1:0];
            state_in = S_PROBE_EVAL;
         end
         S_PROBE_EVAL: begin
            if (op_ff == OP_REG && (head_ff[EW] || head_hit)) begin
               if (head_ff[EW]) begin
                  cur_in = '0; state_in = S_REG_WRITE;
               end else begin
                  cur_in = head_ff; wcnt_in = '0; state_in = S_WALK_RD;
               end
            end else if (op_ff == OP_DISP && head_hit) begin
               cur_in = head_ff; wcnt_in = '0; state_in = S_DISP_RD;
            end else if (op_ff == OP_UNREG && head_hit) begin
               cur_in = head_ff; prev_in = NIL; wcnt_in = '0;
               state_in = S_WALK_RD;
            end else if (pcnt_ff == (SW+1)'(HASH_SLOTS - 1)) begin
               st_in = (op_ff == OP_REG) ? ST_TABLE_FULL : ST_NOT_FOUND;
               state_in = S_RESP;
            end else begin
               pcnt_in = pcnt_ff + 1'b1;
               slot_in = (slot_ff == SW'(HASH_SLOTS - 1)) ? '0 : slot_ff + 1'b1;
               state_in = S_PROBE_RD;
            end
         end
         S_WALK_RD: begin
            e_ra = cur_ff[EW-1:0];
            state_in = S_WALK_EVAL;
         end
         S_WALK_EVAL: begin
            ent_in = e_rd;
            if (op_ff == OP_REG) begin
               if (rd_next[EW] || wcnt_ff == (EW+1)'(POOL_ENTRIES - 1)) begin
                  e_we = 1'b1; e_wa = cur_ff[EW-1:0];
                  e_wd = pack_ent(rd_key, rd_hnd, rd_par, free_ff, rd_tag);
                  state_in = S_REG_WRITE;
               end else begin
                  wcnt_in = wcnt_ff + 1'b1; cur_in = rd_next;
                  state_in = S_WALK_RD;
               end
            end else begin
               if (cur_ff == PW'(hidx_ff)) begin
                  if (prev_ff == NIL) begin
                     s_we = 1'b1; s_wa = slot_ff; s_wd = rd_next;
                     state_in = S_UNREG_WRITE;
                  end else begin
                     // rewrite prev with next: prev entry is read back from entry memory
                     cur_in = rd_next;
                     state_in = S_UNREG_WRITE;
                     e_ra = prev_ff[EW-1:0];
                  end
               end else if (rd_next[EW] || wcnt_ff == (EW+1)'(POOL_ENTRIES - 1)) begin
                  // not in this slot, resume probing
                  if (pcnt_ff == (SW+1)'(HASH_SLOTS - 1)) begin
                     st_in = ST_NOT_FOUND; state_in = S_RESP;
                  end else begin
                     pcnt_in = pcnt_ff + 1'b1;
                     slot_in = (slot_ff == SW'(HASH_SLOTS - 1)) ? '0 : slot_ff + 1'b1;
                     state_in = S_PROBE_RD;
                  end
               end else begin
                  wcnt_in = wcnt_ff + 1'b1; prev_in = cur_ff; cur_in = rd_next;
                  state_in = S_WALK_RD;
               end
            end
         end
         S_UNREG_WRITE: begin
            if (prev_ff != NIL) begin
               // e_rd holds prev entry
               e_we = 1'b1; e_wa = prev_ff[EW-1:0];
               e_wd = pack_ent(rd_key, rd_hnd, rd_par, cur_ff, rd_tag);
               prev_in = NIL;
               cur_in = PW'(hidx_ff);
               state_in = S_UNREG_WRITE;
            end else begin
               e_we = 1'b1; e_wa = hidx_ff[EW-1:0];
               e_wd = pack_ent(key_ff, ent_ff[79:64], ent_ff[143:80], free_ff,
                  ent_ff[144+PW +: 16]);
               used_in[hidx_ff[EW-1:0]] = 1'b0;
               free_in = PW'(hidx_ff);
               st_in = ST_OK; state_in = S_RESP;
            end
         end
         S_REG_WRITE: begin
            // read free head entry for its next and tag
            e_ra = free_ff[EW-1:0];
            cur_in = NIL;
            if (cur_ff == NIL) begin
               e_we = 1'b1; e_wa = free_ff[EW-1:0];
               e_wd = pack_ent(key_ff, hid_ff, hpar_ff, NIL, rd_tag + 16'd1);
               used_in[free_ff[EW-1:0]] = 1'b1;
               if (head_ff[EW]) begin
                  s_we = 1'b1; s_wa = slot_ff; s_wd = free_ff;
               end
               free_in = rd_next;
               oidx_in = 5'(free_ff); otag_in = rd_tag + 16'd1;
               st_in = ST_OK; state_in = S_RESP;
            end
         end
         S_DISP_RD: begin
            e_ra = cur_ff[EW-1:0];
            state_in = S_DISP_OUT;
         end
         S_DISP_OUT: begin
            st_in = ST_OK; och_in = rd_hnd; op0_in = rd_par;
            olast_in = rd_next[EW] || wcnt_ff == (EW+1)'(MAX_OUT - 1);
            cur_in = rd_next;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_tready) begin
               if (op_ff == OP_DISP && st_ff == ST_OK && !olast_ff) begin
                  wcnt_in = wcnt_ff + 1'b1; state_in = S_DISP_RD;
               end else state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == S_IDLE);
      rsp_tvalid = (state_ff == S_RESP);
      rsp_tdata = {ep2_ff & {64{och_valid()}}, ep1_ff & {64{och_valid()}},
         op0_ff, och_ff, otag_ff, oidx_ff, st_ff};
      rsp_tlast = olast_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         used_ff <= '0;
         free_ff <= '0;
         op_ff <= OP_NONE;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         used_ff <= used_in;
         free_ff <= free_in;
         op_ff <= op_in;
      end
      key_ff <= key_in; hid_ff <= hid_in; hpar_ff <= hpar_in;
      hidx_ff <= hidx_in; htag_ff <= htag_in; ep1_ff <= ep1_in; ep2_ff <= ep2_in;
      slot_ff <= slot_in; pcnt_ff <= pcnt_in; head_ff <= head_in;
      cur_ff <= cur_in; prev_ff <= prev_in; wcnt_ff <= wcnt_in;
      st_ff <= st_in; oidx_ff <= oidx_in; otag_ff <= otag_in; och_ff <= och_in;
      op0_ff <= op0_in; olast_ff <= olast_in; ent_ff <= ent_in;
   end
endmodule
`default_nettype wire

// ===== tb/tb_message_subscription_table.sv =====
// testbench for message_subscription_table: directed and random register,
// unregister and dispatch transfers checked against a scoreboard that tracks
// the slot table, handler lists and free list; depends on mst_pkg and the rtl
`default_nettype none
module tb_message_subscription_table;
   timeunit 1ns;
   timeprecision 1ps;
   import mst_pkg::*;

   localparam int POOL = 32;
   localparam int SLOTS = 64;
   localparam int NUM_RANDOM = 410;
   localparam int CYCLE_LIMIT = 3000000;

   typedef struct {
      status_type status;
      logic [4:0] index;
      logic [15:0] tag;
      logic [15:0] handler;
      logic [63:0] p0, p1, p2;
      logic last;
   } call_type;

   class subscription_scoreboard;
      int slot_head[SLOTS];
      logic [63:0] ent_key[POOL];
      int ent_next[POOL];
      logic [15:0] ent_handler[POOL];
      logic [63:0] ent_param[POOL];
      logic [15:0] ent_tag[POOL];
      bit ent_used[POOL];
      int free_head;
      call_type calls_due[$];
      int errors;

      function new();
         for (int i = 0; i < SLOTS; i++) slot_head[i] = -1;
         for (int i = 0; i < POOL; i++) begin
            ent_tag[i] = 0;
            ent_used[i] = 0;
            ent_key[i] = 0;
            ent_next[i] = (i + 1 < POOL) ? i + 1 : -1;
         end
         free_head = 0;
         errors = 0;
      endfunction

      function bit slot_has_key(int s, logic [63:0] k);
         return slot_head[s] >= 0 && ent_key[slot_head[s]] == k;
      endfunction

      function bit unlink(int s, int e);
         int prev, cur;
         prev = -1;
         cur = slot_head[s];
         for (int n = 0; n < POOL && cur >= 0; n++) begin
            if (cur == e) begin
               if (prev < 0) slot_head[s] = ent_next[cur];
               else ent_next[prev] = ent_next[cur];
               return 1;
            end
            prev = cur;
            cur = ent_next[cur];
         end
         return 0;
      endfunction

      function void push(status_type st, int idx = 0, logic [15:0] tg = 0,
                         logic [15:0] h = 0, logic [63:0] a = 0, logic [63:0] b = 0,
                         logic [63:0] c = 0, logic lst = 1);
         call_type r;
         r.status = st; r.index = idx[4:0]; r.tag = tg; r.handler = h;
         r.p0 = a; r.p1 = b; r.p2 = c; r.last = lst;
         calls_due.push_back(r);
      endfunction

      function void note_request(logic [295:0] d);
         op_type op;
         logic [63:0] key;
         int s, n, e, cur, k, idx;
         bit found;
         op = op_type'(d[1:0]);
         key = d[65:2];
         s = int'(key[5:0]);
         case (op)
            OP_REG: begin
               if (free_head < 0) begin
                  push(ST_POOL_FULL);
                  return;
               end
               found = 0;
               for (n = 0; n < SLOTS; n++) begin
                  if (slot_head[s] < 0 || slot_has_key(s, key)) begin
                     found = 1;
                     break;
                  end
                  s = (s + 1) % SLOTS;
               end
               if (!found) begin
                  push(ST_TABLE_FULL);
                  return;
               end
               e = free_head;
               free_head = ent_next[e];
               if (slot_head[s] < 0) slot_head[s] = e;
               else begin
                  cur = slot_head[s];
                  for (n = 0; n < POOL && ent_next[cur] >= 0; n++) cur = ent_next[cur];
                  ent_next[cur] = e;
               end
               ent_handler[e] = d[81:66];
               ent_param[e] = d[145:82];
               ent_key[e] = key;
               ent_next[e] = -1;
               ent_used[e] = 1;
               ent_tag[e] = ent_tag[e] + 16'd1;
               push(ST_OK, e, ent_tag[e]);
            end
            OP_UNREG: begin
               idx = int'(d[151:146]);
               if (idx >= POOL || !ent_used[idx] || ent_tag[idx] != d[167:152]) begin
                  push(ST_BAD_HANDLE);
                  return;
               end
               s = int'(ent_key[idx][5:0]);
               for (n = 0; n < SLOTS; n++) begin
                  if (slot_has_key(s, ent_key[idx]) && unlink(s, idx)) begin
                     ent_used[idx] = 0;
                     ent_next[idx] = free_head;
                     free_head = idx;
                     push(ST_OK);
                     return;
                  end
                  s = (s + 1) % SLOTS;
               end
               push(ST_NOT_FOUND);
            end
            OP_DISP: begin
               for (n = 0; n < SLOTS; n++) begin
                  if (slot_has_key(s, key)) break;
                  s = (s + 1) % SLOTS;
               end
               if (n == SLOTS) begin
                  push(ST_NOT_FOUND);
                  return;
               end
               cur = slot_head[s];
               k = 0;
               while (cur >= 0 && k < MAX_OUT) begin
                  push(ST_OK, 0, 0, ent_handler[cur], ent_param[cur], d[231:168],
                       d[295:232], (ent_next[cur] < 0) || (k + 1 == MAX_OUT));
                  k++;
                  cur = ent_next[cur];
               end
            end
            default: ;
         endcase
      endfunction

      function void check_call(logic [231:0] d, logic lst);
         call_type x;
         if (calls_due.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result transfer %h last %b", d, lst);
            return;
         end
         x = calls_due.pop_front();
         if (d[2:0] !== x.status || d[7:3] !== x.index || d[23:8] !== x.tag ||
             d[39:24] !== x.handler || d[103:40] !== x.p0 || d[167:104] !== x.p1 ||
             d[231:168] !== x.p2 || lst !== x.last) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: exp st %0d idx %0d tag %h h %h p %h %h %h last %b",
                        x.status, x.index, x.tag, x.handler, x.p0, x.p1, x.p2, x.last,
                        "\n          got st %0d idx %0d tag %h h %h p %h %h %h last %b",
                        d[2:0], d[7:3], d[23:8], d[39:24], d[103:40], d[167:104],
                        d[231:168], lst);
         end
      endfunction

      function int pick_used();
         int start;
         start = $urandom_range(POOL - 1);
         for (int i = 0; i < POOL; i++)
            if (ent_used[(start + i) % POOL]) return (start + i) % POOL;
         return -1;
      endfunction
   endclass

   logic clock, reset;
   logic req_tvalid, req_tready;
   logic [295:0] req_tdata;
   logic rsp_tvalid, rsp_tready, rsp_tlast;
   logic [231:0] rsp_tdata;
   bit long_hold;
   int sent;
   longint cycles = 0;
   logic [63:0] keyset[8];
   subscription_scoreboard sb;

   message_subscription_table dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [295:0] pack(op_type op, logic [63:0] key,
                                         logic [15:0] hid, logic [63:0] hp,
                                         logic [5:0] hidx, logic [15:0] htag,
                                         logic [63:0] e1, logic [63:0] e2);
      return {e2, e1, htag, hidx, hp, hid, key, op};
   endfunction

   function automatic int pick_gap(bit busy);
      if (!busy || $urandom_range(99) < 60) return 0;
      if ($urandom_range(99) < 90) return $urandom_range(3, 1);
      return $urandom_range(60, 15);
   endfunction

   task automatic send(logic [295:0] d);
      int gap;
      gap = pick_gap((sent / 100) % 2 == 1);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      sb.note_request(d);
      sent++;
   endtask

   task automatic send_unreg(int idx, logic [15:0] tg);
      send(pack(OP_UNREG, rand64(), 16'($urandom), rand64(), idx[5:0], tg, rand64(),
                rand64()));
   endtask

   task automatic send_key(op_type op, logic [63:0] key, logic [15:0] hid,
                           logic [63:0] p);
      send(pack(op, key, hid, p, 6'($urandom), 16'($urandom), p, ~p));
   endtask

   // result side ready with random stalls
   initial begin
      int stall;
      stall = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold) rsp_tready <= 1'b0;
         else if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else if ((cycles / 3000) % 3 == 0 || $urandom_range(99) < 65) begin
            rsp_tready <= 1'b1;
         end else begin
            stall = ($urandom_range(99) < 90) ? $urandom_range(3, 1)
                                               : $urandom_range(50, 15);
            rsp_tready <= 1'b0;
         end
      end
   end

   // long back-pressure stretch while requests keep coming
   initial begin
      long_hold = 0;
      wait (sent >= 150);
      @(posedge clock);
      long_hold <= 1'b1;
      repeat (600) @(posedge clock);
      long_hold <= 1'b0;
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) sb.check_call(rsp_tdata, rsp_tlast);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      logic [63:0] k0, k1, kmax;
      int s, idx, opsel, fill;
      bit one_key;
      sb = new();
      sent = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed part
      k0 = rand64();
      k1 = k0 + 64;
      kmax = '1;
      send_key(OP_DISP, k0, 0, '1);
      send_unreg(40, 0);
      send_unreg(63, 16'hffff);
      send_unreg(0, 0);
      send_key(OP_REG, k0, 16'hffff, '1);
      send_key(OP_REG, k0, 16'h0000, '0);
      send_key(OP_REG, k1, 16'h5a5a, rand64());
      send_key(OP_DISP, k0, 0, '1);
      send_unreg(0, sb.ent_tag[0] + 16'd1);
      send_unreg(0, sb.ent_tag[0]);
      send_unreg(1, sb.ent_tag[1]);
      // home slot of k0 and k1 is now empty, so k1 gets it as well as the next one
      send_key(OP_REG, k1, 16'h1234, rand64());
      send_key(OP_DISP, k1, 0, rand64());
      send_unreg(2, sb.ent_tag[2]);
      send_unreg(2, sb.ent_tag[2] - 16'd1);
      send(pack(OP_NONE, rand64(), 16'($urandom), rand64(), 6'($urandom),
                16'($urandom), rand64(), rand64()));
      send_key(OP_DISP, kmax, 0, '0);
      send_key(OP_REG, kmax, 16'hffff, '1);
      send_key(OP_DISP, kmax, 0, '1);
      send_key(OP_REG, '0, 16'h0001, '0);
      send_key(OP_DISP, '0, 0, '0);

      // random part: alternating fill and drain phases over a small key set
      for (int i = 0; i < 8; i++) keyset[i] = (i < 4) ? rand64() : keyset[0] + 64 * i;
      fill = 1;
      one_key = 0;
      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n % 50 == 0) begin
            fill = !fill;
            one_key = fill && ($urandom_range(2) == 0);
         end
         opsel = $urandom_range(99);
         s = one_key ? 0 : $urandom_range(7);
         if (opsel < (fill ? 55 : 15)) begin
            send_key(OP_REG, ($urandom_range(19) == 0) ? rand64() : keyset[s],
                     16'($urandom), rand64());
         end else if (opsel < 75) begin
            idx = sb.pick_used();
            if (idx >= 0 && $urandom_range(9) < 8) send_unreg(idx, sb.ent_tag[idx]);
            else send_unreg($urandom_range(63), 16'($urandom));
         end else if (opsel < 96) begin
            send(pack(OP_DISP, ($urandom_range(9) == 0) ? rand64() : keyset[s],
                      16'($urandom), rand64(), 6'($urandom), 16'($urandom), rand64(),
                      rand64()));
         end else begin
            send(pack(OP_NONE, rand64(), 16'($urandom), rand64(), 6'($urandom),
                      16'($urandom), rand64(), rand64()));
         end
      end
      req_tvalid <= 1'b0;

      while (sb.calls_due.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (sb.errors == 0 && sb.calls_due.size() == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule
`default_nettype wire
